/* hdl/rbd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_pkg
// shared types, codes and field widths of the ring buffer deque
// ----------------------------------------------------------------------------
package rbd_pkg;

    // default build sizes
    localparam int DEPTH_DEFAULT      = 16;
    localparam int DATA_WIDTH_DEFAULT = 32;

    // fixed field widths of the stream words
    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int VALUE_W  = 32;
    localparam int COUNT_W  = 5;

    // request codes
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = 2'd0;
    localparam logic [OP_W-1:0] OP_PUSH_FRONT = 2'd1;
    localparam logic [OP_W-1:0] OP_POP_FRONT  = 2'd2;
    localparam logic [OP_W-1:0] OP_PEEK_FRONT = 2'd3;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

    // controller states
    typedef enum logic
    {
        S_IDLE,
        S_READ
    } state_t;

    // controller to datapath
    typedef struct packed
    {
        logic take;       // request word accepted this cycle
        logic load_read;  // ram read data is valid, load it into the result
    } rbd_cmd_t;

    // datapath to controller
    typedef struct packed
    {
        logic out_free;   // result register empty or being taken
        logic needs_read; // pending request is a pop or peek on a non-empty store
    } rbd_stat_t;

endpackage

/* hdl/ring_buffer_deque.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ring_buffer_deque
// fixed-capacity double-ended queue in a circular slot ram
// ----------------------------------------------------------------------------
// each request word carries an op in s_tuser (push back, push front, pop
// front, peek front) and the value to push in s_tdata; each request gives
// exactly one result word with a status in m_tuser (ok, full, empty) and the
// front value (zero for pushes and on an empty store) and element count in
// m_tdata. one request is in flight at a time, so pushes sustain one word
// per cycle while results are taken; a pop or peek on a non-empty store
// holds off the next request until the registered slot ram read data is
// loaded into the result. a result waiting on m_tready holds off the next
// request, but the result register frees in the cycle it is taken, so a
// new request can be accepted in that same cycle. slots hold no reset value;
// only slots that hold a stored element are ever read. capacity is DEPTH
// elements, values are stored in their low DATA_WIDTH bits
module ring_buffer_deque #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] data_in
    input  logic [1:0]  s_tuser,   // [1:0] op
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [39:0] m_tdata,   // [31:0] data_out, [36:32] count, [39:37] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    import rbd_pkg::*;

    rbd_cmd_t  cmd;
    rbd_stat_t stat;

    logic [STATUS_W-1:0] status;
    logic [VALUE_W-1:0]  data_out;
    logic [COUNT_W-1:0]  count;

    // sequencer that accepts, then waits in a read state for the ram on a non-empty pop or peek
    rbd_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // pointers, count, slot ram and the result register
    rbd_datapath #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (s_tuser),
        .data_in   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .status    (status),
        .data_out  (data_out),
        .count     (count)
    );

    // result word packing, highest field first
    assign m_tdata = {3'b000, count, data_out};
    assign m_tuser = status;

endmodule

/* hdl/rbd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
module rbd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/rbd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_ctrl
// request sequencer: accepts a word, waits out the ram read for a non-empty pop or peek
// ----------------------------------------------------------------------------
module rbd_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  rbd_pkg::rbd_stat_t stat,
    output rbd_pkg::rbd_cmd_t  cmd
);

    import rbd_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid && stat.out_free && stat.needs_read)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        in_ready      = 1'b0;
        cmd.take      = 1'b0;
        cmd.load_read = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = stat.out_free;
                cmd.take = in_valid && stat.out_free;
            end
            S_READ:
            begin
                cmd.load_read = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

/* hdl/rbd_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbd_datapath
// head and tail pointers, fill count, slot ram and result register
// ----------------------------------------------------------------------------
module rbd_datapath #(
    parameter int DEPTH      = rbd_pkg::DEPTH_DEFAULT,
    parameter int DATA_WIDTH = rbd_pkg::DATA_WIDTH_DEFAULT
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic [rbd_pkg::OP_W-1:0]       op,
    input  logic [rbd_pkg::VALUE_W-1:0]    data_in,
    input  rbd_pkg::rbd_cmd_t              cmd,
    output rbd_pkg::rbd_stat_t             stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rbd_pkg::STATUS_W-1:0]   status,
    output logic [rbd_pkg::VALUE_W-1:0]    data_out,
    output logic [rbd_pkg::COUNT_W-1:0]    count
);

    import rbd_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    logic [AW-1:0] head_reg, head_next;
    logic [AW-1:0] tail_reg, tail_next;
    logic [CW-1:0] fill_reg, fill_next;

    logic                 out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]  status_reg, status_next;
    logic [VALUE_W-1:0]   data_reg, data_next;
    logic [COUNT_W-1:0]   count_reg, count_next;

    logic                  is_push;
    logic                  is_full;
    logic                  is_empty;
    logic                  ram_we;
    logic                  ram_re;
    logic [AW-1:0]         ram_waddr;
    logic [DATA_WIDTH-1:0] ram_wdata;
    logic [DATA_WIDTH-1:0] ram_rdata;

    logic [DATA_WIDTH+VALUE_W-1:0] win_ext;
    logic [DATA_WIDTH+VALUE_W-1:0] rout_ext;
    logic [CW+COUNT_W-1:0]         cnt_ext;

    function automatic logic [AW-1:0] idx_inc(input logic [AW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + 1'b1;
    endfunction

    function automatic logic [AW-1:0] idx_dec(input logic [AW-1:0] i);
        return (i == '0) ? LAST_IDX : i - 1'b1;
    endfunction

    assign is_push  = (op == OP_PUSH_BACK) || (op == OP_PUSH_FRONT);
    assign is_full  = (fill_reg == FULL_CNT);
    assign is_empty = (fill_reg == '0);

    assign stat.out_free   = !out_valid_reg || out_ready;
    assign stat.needs_read = !is_push && !is_empty;

    assign win_ext   = {{DATA_WIDTH{1'b0}}, data_in};
    assign ram_wdata = win_ext[DATA_WIDTH-1:0];
    assign rout_ext  = {{VALUE_W{1'b0}}, ram_rdata};

    // pointer and count update, ram access
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        ram_we    = 1'b0;
        ram_re    = 1'b0;
        ram_waddr = tail_reg;
        if (cmd.take)
        begin
            unique case (op)
                OP_PUSH_BACK:
                begin
                    if (!is_full)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = tail_reg;
                        tail_next = idx_inc(tail_reg);
                        fill_next = fill_reg + 1'b1;
                    end
                end
                OP_PUSH_FRONT:
                begin
                    if (!is_full)
                    begin
                        ram_we    = 1'b1;
                        ram_waddr = idx_dec(head_reg);
                        head_next = idx_dec(head_reg);
                        fill_next = fill_reg + 1'b1;
                    end
                end
                OP_POP_FRONT:
                begin
                    if (!is_empty)
                    begin
                        ram_re    = 1'b1;
                        head_next = idx_inc(head_reg);
                        fill_next = fill_reg - 1'b1;
                    end
                end
                OP_PEEK_FRONT:
                begin
                    ram_re = !is_empty;
                end
                default:
                begin
                    ram_re = 1'b0;
                end
            endcase
        end
    end

    assign cnt_ext = {{COUNT_W{1'b0}}, fill_next};

    // result register
    always_comb
    begin
        out_valid_next = out_valid_reg && !out_ready;
        status_next    = status_reg;
        data_next      = data_reg;
        count_next     = count_reg;
        priority if (cmd.load_read)
        begin
            out_valid_next = 1'b1;
            status_next    = ST_OK;
            data_next      = rout_ext[VALUE_W-1:0];
            count_next     = cnt_ext[COUNT_W-1:0];
        end
        else if (cmd.take && !stat.needs_read)
        begin
            out_valid_next = 1'b1;
            status_next    = is_push ? (is_full ? ST_FULL : ST_OK) : ST_EMPTY;
            data_next      = '0;
            count_next     = cnt_ext[COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg      <= '0;
            tail_reg      <= '0;
            fill_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            fill_reg      <= fill_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        data_reg   <= data_next;
        count_reg  <= count_next;
    end

    rbd_ram #(
        .WIDTH (DATA_WIDTH),
        .DEPTH (DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (head_reg),
        .rdata (ram_rdata)
    );

    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign data_out  = data_reg;
    assign count     = count_reg;

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the ring buffer deque
// ----------------------------------------------------------------------------
// request words go in through one send task. at each accepted word it steps
// a shadow deque and queues the result word that request should give. a
// monitor compares every accepted result word, field by field, with the
// oldest queued one. both sides idle at random. the receiver once holds off
// long enough to back the block up, and the sender stops, once between two
// bursts and again at the end, until every queued result has come back
module tb_top;
    import rbd_pkg::*;

    localparam int DEPTH        = DEPTH_DEFAULT;
    localparam int DATA_WIDTH   = DATA_WIDTH_DEFAULT;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 8;
    localparam int MAX_REPORTS  = 10;
    localparam int HOLD_LEN     = 64;

    // values are kept in their low DATA_WIDTH bits
    localparam logic [VALUE_W-1:0] VALUE_MASK = {VALUE_W{1'b1}} >> (VALUE_W - DATA_WIDTH);

    typedef struct packed
    {
        logic [STATUS_W-1:0] status;
        logic [VALUE_W-1:0]  value;
        logic [COUNT_W-1:0]  count;
    } deque_result_t;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;    // [31:0] data_in
    logic [1:0]  s_tuser;    // [1:0] op
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;    // [31:0] data_out, [36:32] count, [39:37] zero
    logic [1:0]  m_tuser;    // [1:0] status

    // shadow copy of the deque
    logic [VALUE_W-1:0] shadow_slots [DEPTH];
    int unsigned        shadow_head = 0;
    int unsigned        shadow_tail = 0;
    int unsigned        shadow_fill = 0;

    deque_result_t pending_results [$];
    int unsigned   mismatch_count = 0;
    int unsigned   cycle_count = 0;

    // idling controls shared by the test tasks and the two sides
    bit          sender_gaps = 1'b1;
    bit          receiver_gaps = 1'b1;
    bit          hold_request = 1'b0;
    int unsigned hold_cycles = 0;

    ring_buffer_deque DUT
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    always #10 clk = ~clk;

    // hard stop if the block hangs
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Mismatches found");
            $finish;
        end
    end

    // one request on the shadow deque, giving the result word it must produce
    function automatic deque_result_t predict_deque_result(input logic [OP_W-1:0] op,
                                                           input logic [VALUE_W-1:0] data);
        deque_result_t res;
        res        = '0;
        res.status = ST_OK;
        case (op)
            OP_PUSH_BACK, OP_PUSH_FRONT:
            begin
                if (shadow_fill >= DEPTH)
                    res.status = ST_FULL;
                else if (op == OP_PUSH_BACK)
                begin
                    shadow_slots[shadow_tail] = data & VALUE_MASK;
                    shadow_tail = (shadow_tail + 1) % DEPTH;
                    shadow_fill++;
                end
                else
                begin
                    // head steps back, wrapping below slot zero
                    shadow_head = (shadow_head + DEPTH - 1) % DEPTH;
                    shadow_slots[shadow_head] = data & VALUE_MASK;
                    shadow_fill++;
                end
            end
            default:
            begin
                if (shadow_fill == 0)
                    res.status = ST_EMPTY;
                else
                begin
                    res.value = shadow_slots[shadow_head];
                    if (op == OP_POP_FRONT)
                    begin
                        shadow_head = (shadow_head + 1) % DEPTH;
                        shadow_fill--;
                    end
                end
            end
        endcase
        res.count = COUNT_W'(shadow_fill);
        return res;
    endfunction

    // mostly full random words, with the extremes and single bits mixed in
    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return VALUE_W'(1) << $urandom_range(0, VALUE_W - 1);
            default: return $urandom;
        endcase
    endfunction

    // push_pct sets how hard the traffic leans toward filling the store
    function automatic logic [OP_W-1:0] pick_op(input int unsigned push_pct);
        if ($urandom_range(0, 99) < push_pct)
            return $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
        else
            return ($urandom_range(0, 3) == 0) ? OP_PEEK_FRONT : OP_POP_FRONT;
    endfunction

    // offer one request word, wait for the handshake, then queue its result
    task automatic send_request(input logic [OP_W-1:0] op, input logic [VALUE_W-1:0] data);
        int unsigned gap;
        gap = sender_gaps ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        pending_results.push_back(predict_deque_result(op, data));
    endtask

    // sender goes quiet until every queued result has come back
    task automatic wait_for_results();
        s_tvalid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
    endtask

    task automatic record_mismatch(input string what, input deque_result_t want,
                                   input deque_result_t got);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: %s: expected status %0d data %h count %0d, ",
                      "got status %0d data %h count %0d pad %b"},
                     $time, what, want.status, want.value, want.count,
                     got.status, got.value, got.count, m_tdata[39:VALUE_W+COUNT_W]);
    endtask

    // empty store, both extremes, head wrap, full refusal on both pushes
    task automatic test_directed();
        int unsigned i;
        send_request(OP_POP_FRONT, '1);       // empty, data ignored
        send_request(OP_PEEK_FRONT, '1);
        send_request(OP_PUSH_BACK, '0);
        send_request(OP_PUSH_FRONT, '1);      // head wraps to the top slot
        send_request(OP_PEEK_FRONT, '0);
        for (i = 0; i < DEPTH - 2; i++)
            send_request((i % 2) ? OP_PUSH_FRONT : OP_PUSH_BACK, pick_value());
        send_request(OP_PUSH_BACK, pick_value());   // refused, store full
        send_request(OP_PUSH_FRONT, pick_value());
        send_request(OP_PEEK_FRONT, pick_value());
        repeat (3) send_request(OP_POP_FRONT, pick_value());
    endtask

    // receiver stalls for a long stretch while requests keep coming back to back
    task automatic test_backpressure();
        sender_gaps  = 1'b0;
        hold_cycles  = HOLD_LEN;
        hold_request = 1'b1;
        s_tvalid    <= 1'b0;
        @(posedge clk);
        repeat (40) send_request(pick_op(60), pick_value());
        sender_gaps = 1'b1;
    endtask

    // phases that lean to fill, to drain or neither, with idling on and off
    task automatic test_random_traffic(input int unsigned total);
        int unsigned sent;
        int unsigned run;
        int unsigned push_pct;
        sent = 0;
        while (sent < total)
        begin
            run = $urandom_range(20, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 80;
                1: push_pct = 20;
                default: push_pct = 50;
            endcase
            sender_gaps   = ($urandom_range(0, 3) != 0);
            receiver_gaps = ($urandom_range(0, 3) != 0);
            repeat (run)
            begin
                send_request(pick_op(push_pct), pick_value());
                sent++;
            end
        end
        sender_gaps   = 1'b1;
        receiver_gaps = 1'b1;
    endtask

    // block runs dry between two bursts
    task automatic test_drain_pause();
        repeat (20) send_request(pick_op(80), pick_value());
        wait_for_results();
        repeat (20) send_request(pick_op(20), pick_value());
    endtask

    // receiver: a random stall after each result word, or a long hold on request
    initial
    begin : rx_ready_driver
        int unsigned stall_left;
        stall_left = 0;
        m_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                stall_left = receiver_gaps ? $urandom_range(0, 7) : 0;
            if (hold_request)
            begin
                hold_request = 1'b0;
                stall_left   = hold_cycles;
            end
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
                m_tready <= 1'b1;
        end
    end

    // every accepted result word against the oldest queued one
    always @(posedge clk)
    begin : result_monitor
        deque_result_t want;
        deque_result_t got;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.status = m_tuser;
            got.value  = m_tdata[VALUE_W-1:0];
            got.count  = m_tdata[VALUE_W +: COUNT_W];
            if (pending_results.size() == 0)
                record_mismatch("unexpected result word", '0, got);
            else
            begin
                want = pending_results.pop_front();
                if (got !== want || m_tdata[39:VALUE_W+COUNT_W] !== '0)
                    record_mismatch("result word differs", want, got);
            end
        end
    end

    initial
    begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= OP_PUSH_BACK;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_backpressure();
        test_random_traffic(400);
        test_drain_pause();

        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

/* ring_buffer_deque.f */
hdl/rbd_pkg.sv
hdl/rbd_ram.sv
hdl/rbd_ctrl.sv
hdl/rbd_datapath.sv
hdl/ring_buffer_deque.sv
dv/tb_top.sv
